FILE: design/hnq_pkg.sv
package hnq_pkg;

    // Default grid side; the top level hands it down as a parameter
    localparam int MAP_SIDE_DEF = 256;

    // Configuration port shape
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_SIDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_UNIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y   = 3'd5;

    // Operation codes carried in the mode field
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_HEIGHT = 2'd1;
    localparam logic [1:0] MODE_NORMAL = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // Status of the normalize unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_nu_sts;

endpackage

FILE: design/hnq_item_if.sv
interface hnq_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic [7:0]         row;
    logic [7:0]         column;
    logic [7:0]         sample;
    logic signed [23:0] world_x;
    logic signed [23:0] world_z;

    modport source (output valid, mode, row, column, sample, world_x, world_z, input ready);
    modport sink   (input valid, mode, row, column, sample, world_x, world_z, output ready);
endinterface

FILE: design/hnq_res_if.sv
interface hnq_res_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] height;
    logic               outside;
    logic signed [15:0] normal_x;
    logic [14:0]        normal_y;
    logic signed [15:0] normal_z;

    modport source (output valid, height, outside, normal_x, normal_y, normal_z, input ready);
    modport sink   (input valid, height, outside, normal_x, normal_y, normal_z, output ready);
endinterface

FILE: design/hnq_norm.sv
module hnq_norm
    import hnq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [51:0]        i_sum,
    input  logic signed [26:0] i_dx,
    input  logic signed [26:0] i_dz,
    output t_nu_sts            o_sts,
    output logic signed [15:0] o_nx,
    output logic [14:0]        o_ny,
    output logic signed [15:0] o_nz
);

    typedef enum logic [2:0] {N_IDLE, N_SQRT, N_DSET, N_DIV, N_DONE} t_nstate;

    t_nstate            r_state;
    logic [63:0]        r_op;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [4:0]         r_cnt;
    logic [1:0]         r_comp;
    logic [31:0]        r_drem;
    logic [15:0]        r_num_lo;
    logic [15:0]        r_q;
    logic signed [26:0] r_dx;
    logic signed [26:0] r_dz;
    logic signed [15:0] r_nx;
    logic [14:0]        r_ny;
    logic signed [15:0] r_nz;

    logic [35:0] sq_w;
    logic [35:0] sq_t;
    logic [25:0] mag;
    logic [47:0] num;
    logic [32:0] dv_w;
    logic [15:0] q_n;
    logic        neg;

    always_comb begin
        sq_w = {r_rem, r_op[63:62]};
        sq_t = {2'b00, r_root, 2'b01};
        case (r_comp)
            2'd0:    mag = r_dx[26] ? 26'(-r_dx) : 26'(r_dx);
            2'd1:    mag = 26'd32768;
            default: mag = r_dz[26] ? 26'(-r_dz) : 26'(r_dz);
        endcase
        neg  = (r_comp == 2'd0) ? r_dx[26] : ((r_comp == 2'd2) ? r_dz[26] : 1'b0);
        num  = {2'b00, mag, 20'b0} + {17'b0, r_root[31:1]};
        dv_w = {r_drem, r_num_lo[15]};
        q_n  = {r_q[14:0], (dv_w >= {1'b0, r_root})};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
        end else begin
            case (r_state)
                N_IDLE: begin
                    if (i_start) begin
                        r_op    <= {i_sum, 12'b0};
                        r_rem   <= '0;
                        r_root  <= '0;
                        r_cnt   <= '0;
                        r_comp  <= '0;
                        r_dx    <= i_dx;
                        r_dz    <= i_dz;
                        r_state <= N_SQRT;
                    end
                end
                N_SQRT: begin
                    // one root bit per cycle
                    if (sq_w >= sq_t) begin
                        r_rem  <= 34'(sq_w - sq_t);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= sq_w[33:0];
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_op  <= {r_op[61:0], 2'b00};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= N_DSET;
                    end
                end
                N_DSET: begin
                    r_drem   <= num[47:16];
                    r_num_lo <= num[15:0];
                    r_q      <= '0;
                    r_cnt    <= '0;
                    r_state  <= N_DIV;
                end
                N_DIV: begin
                    // one quotient bit per cycle
                    if (dv_w >= {1'b0, r_root}) begin
                        r_drem <= 32'(dv_w - {1'b0, r_root});
                    end else begin
                        r_drem <= dv_w[31:0];
                    end
                    r_q      <= q_n;
                    r_num_lo <= {r_num_lo[14:0], 1'b0};
                    r_cnt    <= r_cnt + 5'd1;
                    if (r_cnt == 5'd15) begin
                        case (r_comp)
                            2'd0:    r_nx <= neg ? -signed'(q_n) : signed'(q_n);
                            2'd1:    r_ny <= q_n[14:0];
                            default: r_nz <= neg ? -signed'(q_n) : signed'(q_n);
                        endcase
                        r_comp  <= r_comp + 2'd1;
                        r_state <= (r_comp == 2'd2) ? N_DONE : N_DSET;
                    end
                end
                N_DONE: r_state <= N_IDLE;
                default: r_state <= N_IDLE;
            endcase
        end
    end

    assign o_sts.busy = (r_state != N_IDLE);
    assign o_sts.done = (r_state == N_DONE);
    assign o_nx = r_nx;
    assign o_ny = r_ny;
    assign o_nz = r_nz;

endmodule

FILE: design/heightfield_normal_and_height_query.sv
// One transaction at a time: the next item is accepted in the cycle after the result loads
// into the output register. Write and idle-mode transactions go straight to the output; a
// height query reads four vertices unless its point falls outside the map, and a normal
// query reads four vertices, then waits on the bit-serial root and three divides in
// hnq_norm.
// Reset: synchronous, active low; clears control and configuration, not the height map.
module heightfield_normal_and_height_query
    import hnq_pkg::*;
#(
    parameter int MAP_SIDE = MAP_SIDE_DEF
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    hnq_item_if.sink             i_item,
    hnq_res_if.source            o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W  = $clog2(MAP_SIDE);
    localparam int DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    // grid coordinate compare width, set by the integer part of the scaled product
    localparam int CW     = 30;

    typedef enum logic [4:0] {
        S_IDLE, S_GX, S_GZ, S_CHK, S_RD, S_CAP, S_TRI, S_M1, S_M2, S_M3, S_HFIN,
        S_NDIF, S_NSQ1, S_NSQ2, S_NSQ3, S_NWAIT, S_OUT
    } t_state;

    // configuration
    logic [8:0]         r_side;
    logic [15:0]        r_maxh;
    logic [23:0]        r_cpu;
    logic signed [23:0] r_ox;
    logic signed [23:0] r_oz;
    logic signed [23:0] r_oy;

    t_state             r_state;
    logic               r_is_norm;
    logic [1:0]         r_cnt;
    logic [ADDR_W-1:0]  r_addr [4];
    logic signed [25:0] r_h [4];
    logic [7:0]         r_rdata;
    logic signed [26:0] r_dx;
    logic signed [26:0] r_dz;
    logic signed [53:0] r_prod;
    logic signed [53:0] r_gx;
    logic [23:0]        r_fx;
    logic [23:0]        r_fz;
    logic signed [26:0] r_base;
    logic signed [26:0] r_d1;
    logic signed [26:0] r_d2;
    logic signed [55:0] r_acc;

    // pending result and output register
    logic signed [24:0] r_p_height;
    logic               r_p_out;
    logic signed [15:0] r_p_nx;
    logic [14:0]        r_p_ny;
    logic signed [15:0] r_p_nz;
    logic               r_ov;
    logic signed [24:0] r_o_height;
    logic               r_o_out;
    logic signed [15:0] r_o_nx;
    logic [14:0]        r_o_ny;
    logic signed [15:0] r_o_nz;

    logic [7:0] mem [DEPTH];

    logic [CW-1:0]      side_c;
    logic [CW-1:0]      sm1;
    logic               acc_in;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_wa;
    logic [CW-1:0]      ni, nj, nil, nir, nju, njd;
    logic [CW-1:0]      ix, iz;
    logic               out_x;
    logic [24:0]        fsum;
    logic signed [26:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [53:0] mul_p;
    logic signed [55:0] rnd;
    logic [51:0]        nsum;
    logic               nu_start;
    t_nu_sts            nu_sts;
    logic signed [15:0] nu_nx;
    logic [14:0]        nu_ny;
    logic signed [15:0] nu_nz;

    function automatic logic [ADDR_W-1:0] f_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return ADDR_W'(r * CW'(MAP_SIDE) + c);
    endfunction

    function automatic logic signed [25:0] f_vert(input logic [7:0] b, input logic [15:0] mh);
        logic signed [8:0] s;
        s = $signed({1'b0, b}) - 9'sd128;
        return s * $signed({1'b0, mh});
    endfunction

    assign acc_in = i_item.valid && i_item.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // clamp the side in use to [2, MAP_SIDE]
    always_comb begin
        if (r_side < 9'd2) begin
            side_c = CW'(2);
        end else if (CW'(r_side) > CW'(MAP_SIDE)) begin
            side_c = CW'(MAP_SIDE);
        end else begin
            side_c = CW'(r_side);
        end
        sm1 = side_c - CW'(1);
    end

    // normal query: clamp the point, then its four neighbors at the map edge
    always_comb begin
        ni  = (CW'(i_item.row) > sm1) ? sm1 : CW'(i_item.row);
        nj  = (CW'(i_item.column) > sm1) ? sm1 : CW'(i_item.column);
        nil = (ni == '0) ? ni : ni - CW'(1);
        nir = (ni == sm1) ? ni : ni + CW'(1);
        nju = (nj == '0) ? nj : nj - CW'(1);
        njd = (nj == sm1) ? nj : nj + CW'(1);
    end

    // height query: integer cell and outside test, gz is in r_prod during S_CHK
    always_comb begin
        ix    = r_gx[53:24];
        iz    = r_prod[53:24];
        out_x = r_gx[53] || r_prod[53] || (ix >= sm1) || (iz >= sm1);
        fsum  = {1'b0, r_fx} + {1'b0, r_fz};
        rnd   = r_acc + (56'sd1 <<< 30);
        nsum  = r_acc[51:0] + r_prod[51:0] + (52'd1 << 30);
    end

    // write port: store a sample only when it lands inside the map
    assign mem_we = acc_in && (i_item.mode == MODE_WRITE)
                    && (CW'(i_item.row) < CW'(MAP_SIDE))
                    && (CW'(i_item.column) < CW'(MAP_SIDE));
    assign mem_wa = f_addr(CW'(i_item.row), CW'(i_item.column));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= i_item.sample;
        end
        r_rdata <= mem[r_addr[r_cnt]];
    end

    // shared multiplier, product registered every cycle
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_GX: begin
                mul_a = r_dx;
                mul_b = $signed({3'b000, r_cpu});
            end
            S_GZ: begin
                mul_a = r_dz;
                mul_b = $signed({3'b000, r_cpu});
            end
            S_M1: begin
                mul_a = $signed({3'b000, r_fx});
                mul_b = r_d1;
            end
            S_M2: begin
                mul_a = $signed({3'b000, r_fz});
                mul_b = r_d2;
            end
            S_NSQ1: begin
                mul_a = r_dx;
                mul_b = r_dx;
            end
            S_NSQ2: begin
                mul_a = r_dz;
                mul_b = r_dz;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
    end

    assign nu_start = (r_state == S_NSQ3);

    hnq_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (nu_start),
        .i_sum   (nsum),
        .i_dx    (r_dx),
        .i_dz    (r_dz),
        .o_sts   (nu_sts),
        .o_nx    (nu_nx),
        .o_ny    (nu_ny),
        .o_nz    (nu_nz)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_side  <= 9'd256;
            r_maxh  <= 16'd256;
            r_cpu   <= 24'd65536;
            r_ox    <= '0;
            r_oz    <= '0;
            r_oy    <= '0;
        end else begin
            // configuration writes; indexes past the list drop
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAP_SIDE:   r_side <= i_cfg_data[8:0];
                    CFG_MAX_HEIGHT: r_maxh <= i_cfg_data[15:0];
                    CFG_CELLS_UNIT: r_cpu  <= i_cfg_data;
                    CFG_ORIGIN_X:   r_ox   <= $signed(i_cfg_data);
                    CFG_ORIGIN_Z:   r_oz   <= $signed(i_cfg_data);
                    CFG_ORIGIN_Y:   r_oy   <= $signed(i_cfg_data);
                    default: ;
                endcase
            end

            // output register: hold until taken
            if (r_state == S_OUT && (!r_ov || o_res.ready)) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (acc_in) begin
                        r_p_height <= '0;
                        r_p_out    <= 1'b0;
                        r_p_nx     <= '0;
                        r_p_ny     <= '0;
                        r_p_nz     <= '0;
                        r_cnt      <= '0;
                        case (i_item.mode)
                            MODE_HEIGHT: begin
                                r_is_norm <= 1'b0;
                                r_dx      <= i_item.world_x - r_ox;
                                r_dz      <= i_item.world_z - r_oz;
                                r_state   <= S_GX;
                            end
                            MODE_NORMAL: begin
                                r_is_norm <= 1'b1;
                                r_addr[0] <= f_addr(nil, nj);
                                r_addr[1] <= f_addr(nir, nj);
                                r_addr[2] <= f_addr(ni, nju);
                                r_addr[3] <= f_addr(ni, njd);
                                r_state   <= S_RD;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_GX: r_state <= S_GZ;
                S_GZ: begin
                    r_gx    <= r_prod;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (out_x) begin
                        r_p_out <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_fx      <= r_gx[23:0];
                        r_fz      <= r_prod[23:0];
                        r_addr[0] <= f_addr(ix, iz);
                        r_addr[1] <= f_addr(ix + CW'(1), iz);
                        r_addr[2] <= f_addr(ix, iz + CW'(1));
                        r_addr[3] <= f_addr(ix + CW'(1), iz + CW'(1));
                        r_state   <= S_RD;
                    end
                end
                S_RD: r_state <= S_CAP;
                S_CAP: begin
                    r_h[r_cnt] <= f_vert(r_rdata, r_maxh);
                    r_cnt      <= r_cnt + 2'd1;
                    if (r_cnt == 2'd3) begin
                        r_state <= r_is_norm ? S_NDIF : S_TRI;
                    end else begin
                        r_state <= S_RD;
                    end
                end
                S_TRI: begin
                    // lower triangle when fx + fz stays within one cell
                    if (fsum <= 25'h1000000) begin
                        r_base <= r_h[0];
                        r_d1   <= r_h[1] - r_h[0];
                        r_d2   <= r_h[2] - r_h[0];
                    end else begin
                        r_base <= r_h[1] + r_h[2] - r_h[3];
                        r_d1   <= r_h[3] - r_h[2];
                        r_d2   <= r_h[3] - r_h[1];
                    end
                    r_state <= S_M1;
                end
                S_M1: r_state <= S_M2;
                S_M2: begin
                    r_acc   <= $signed({{5{r_base[26]}}, r_base, 24'b0}) + r_prod;
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_acc   <= r_acc + r_prod;
                    r_state <= S_HFIN;
                end
                S_HFIN: begin
                    // round half up to Q.8, then add the vertical offset
                    r_p_height <= rnd[55:31] + {r_oy[23], r_oy};
                    r_state    <= S_OUT;
                end
                S_NDIF: begin
                    r_dx    <= r_h[0] - r_h[1];
                    r_dz    <= r_h[2] - r_h[3];
                    r_state <= S_NSQ1;
                end
                S_NSQ1: r_state <= S_NSQ2;
                S_NSQ2: begin
                    r_acc   <= r_prod;
                    r_state <= S_NSQ3;
                end
                S_NSQ3: r_state <= S_NWAIT;
                S_NWAIT: begin
                    if (nu_sts.done) begin
                        r_p_nx  <= nu_nx;
                        r_p_ny  <= nu_ny;
                        r_p_nz  <= nu_nz;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ov || o_res.ready) begin
                        r_o_height <= r_p_height;
                        r_o_out    <= r_p_out;
                        r_o_nx     <= r_p_nx;
                        r_o_ny     <= r_p_ny;
                        r_o_nz     <= r_p_nz;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid    = r_ov;
    assign o_res.height   = r_o_height;
    assign o_res.outside  = r_o_out;
    assign o_res.normal_x = r_o_nx;
    assign o_res.normal_y = r_o_ny;
    assign o_res.normal_z = r_o_nz;

endmodule

FILE: design/hnq_chk.sv
module hnq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [24:0] i_height,
    input logic               i_outside,
    input logic signed [15:0] i_nx,
    input logic [14:0]        i_ny,
    input logic signed [15:0] i_nz
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before taken");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_outside |-> i_height == 0 && i_nx == 0 && i_ny == 0 && i_nz == 0)
        else $error("outside result carries data");

    a_normal_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_ny != 0 |-> !i_outside && i_height == 0)
        else $error("normal result mixed with height");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("accepted while busy");

endmodule

bind heightfield_normal_and_height_query hnq_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_height    (o_res.height),
    .i_outside   (o_res.outside),
    .i_nx        (o_res.normal_x),
    .i_ny        (o_res.normal_y),
    .i_nz        (o_res.normal_z)
);

FILE: tb/tb.sv
module tb;
    import hnq_pkg::*;

    typedef struct {
        logic [1:0]         mode;
        logic [7:0]         row;
        logic [7:0]         column;
        logic [7:0]         sample;
        logic signed [23:0] world_x;
        logic signed [23:0] world_z;
    } map_op_t;

    typedef struct {
        logic [24:0] height;
        logic        outside;
        logic [15:0] normal_x;
        logic [14:0] normal_y;
        logic [15:0] normal_z;
    } query_res_t;

    localparam int QUIET_LIMIT = 3000;

    logic i_clk;
    logic i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    hnq_item_if item_if ();
    hnq_res_if  res_if ();

    heightfield_normal_and_height_query dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Shadow copy of the terrain map and its registers
    logic [7:0]         shadow_map [0:255][0:255];
    bit                 map_written [0:255][0:255];
    logic [8:0]         side_reg;
    logic [15:0]        max_h_reg;
    logic [23:0]        cells_reg;
    logic signed [23:0] org_x_reg;
    logic signed [23:0] org_z_reg;
    logic signed [23:0] org_y_reg;

    query_res_t pending_q [$];
    int         fail_count;
    bit         send_gaps;
    bit         recv_stalls;
    int         quiet_cycles = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Abort when neither channel moves a transaction for too long
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic int grid_side();
        int s;
        s = side_reg;
        if (s < 2) s = 2;
        if (s > 256) s = 256;
        return s;
    endfunction

    // Height of one vertex in units of 2^-15; flag entries never loaded
    function automatic longint vertex_height(int r, int c, inout bit unloaded);
        if (!map_written[r][c]) unloaded = 1'b1;
        return (longint'(shadow_map[r][c]) - 128) * longint'(max_h_reg);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Divide by the vector length in Q1.14, rounding ties away from zero
    function automatic longint scale_to_unit(longint comp, longint unsigned len);
        longint unsigned mag, q;
        mag = (comp < 0) ? -comp : comp;
        q = ((mag << 20) + len / 2) / len;
        return (comp < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Expected result of one transaction; the map itself is not touched here
    function automatic query_res_t predict_query(map_op_t op, output bit unloaded);
        query_res_t         res;
        int                 side, r, c, i, j;
        longint             gx, gz, fx, fz, h00, h10, h01, h11, tot, hgt;
        longint             hl, hr, hu, hd, dx, dz;
        longint unsigned    sq, len;
        res = '{default: '0};
        unloaded = 1'b0;
        side = grid_side();
        if (op.mode == MODE_HEIGHT) begin
            gx = (longint'(op.world_x) - longint'(org_x_reg)) * longint'(cells_reg);
            gz = (longint'(op.world_z) - longint'(org_z_reg)) * longint'(cells_reg);
            if (gx < 0 || gz < 0 || (gx >>> 24) >= side - 1 || (gz >>> 24) >= side - 1) begin
                res.outside = 1'b1;
            end else begin
                r = int'(gx >>> 24);
                c = int'(gz >>> 24);
                fx = gx & 64'hFFFFFF;
                fz = gz & 64'hFFFFFF;
                h00 = vertex_height(r, c, unloaded);
                h10 = vertex_height(r + 1, c, unloaded);
                h01 = vertex_height(r, c + 1, unloaded);
                h11 = vertex_height(r + 1, c + 1, unloaded);
                // Lower triangle when on or below the diagonal
                if (fx + fz <= 64'h1000000)
                    tot = h00 * 64'h1000000 + fx * (h10 - h00) + fz * (h01 - h00);
                else
                    tot = (h10 + h01 - h11) * 64'h1000000 + fx * (h11 - h01)
                        + fz * (h11 - h10);
                hgt = ((tot + (64'sd1 <<< 51) + (64'sd1 <<< 30)) >>> 31) - (64'sd1 <<< 20)
                    + longint'(org_y_reg);
                res.height = hgt[24:0];
            end
        end else if (op.mode == MODE_NORMAL) begin
            // Clamp the grid point, then clamp each neighbour at the map edge
            i = (op.row > side - 1) ? side - 1 : op.row;
            j = (op.column > side - 1) ? side - 1 : op.column;
            hl = vertex_height((i == 0) ? 0 : i - 1, j, unloaded);
            hr = vertex_height((i == side - 1) ? i : i + 1, j, unloaded);
            hu = vertex_height(i, (j == 0) ? 0 : j - 1, unloaded);
            hd = vertex_height(i, (j == side - 1) ? j : j + 1, unloaded);
            dx = hl - hr;
            dz = hu - hd;
            sq = longint'(dx * dx) + longint'(dz * dz) + (64'd1 << 30);
            len = int_sqrt(sq << 12);
            hgt = scale_to_unit(dx, len);
            res.normal_x = hgt[15:0];
            hgt = scale_to_unit(64'sd1 <<< 15, len);
            res.normal_y = hgt[14:0];
            hgt = scale_to_unit(dz, len);
            res.normal_z = hgt[15:0];
        end
        return res;
    endfunction

    // Drive one transaction, wait for accept, then record its expected result and apply a write to the shadow map
    task automatic send_op(map_op_t op);
        int         gap;
        bit         unloaded;
        query_res_t res;
        gap = send_gaps ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            item_if.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_if.mode    = op.mode;
        item_if.row     = op.row;
        item_if.column  = op.column;
        item_if.sample  = op.sample;
        item_if.world_x = op.world_x;
        item_if.world_z = op.world_z;
        item_if.valid   = 1'b1;
        do @(posedge i_clk); while (!item_if.ready);
        res = predict_query(op, unloaded);
        pending_q.insert(pending_q.size(), res);
        if (op.mode == MODE_WRITE) begin
            shadow_map[op.row][op.column] = op.sample;
            map_written[op.row][op.column] = 1'b1;
        end
    endtask

    // Let the block drain, then write one register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(negedge i_clk);
        item_if.valid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (8) @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_MAP_SIDE:   side_reg  = value[8:0];
            CFG_MAX_HEIGHT: max_h_reg = value[15:0];
            CFG_CELLS_UNIT: cells_reg = value[23:0];
            CFG_ORIGIN_X:   org_x_reg = value[23:0];
            CFG_ORIGIN_Z:   org_z_reg = value[23:0];
            CFG_ORIGIN_Y:   org_y_reg = value[23:0];
            default: ;
        endcase
    endtask

    task automatic set_terrain(int side, int max_h, int cells, int ox, int oz, int oy);
        write_reg(CFG_MAP_SIDE, CFG_W'(side));
        write_reg(CFG_MAX_HEIGHT, CFG_W'(max_h));
        write_reg(CFG_CELLS_UNIT, CFG_W'(cells));
        write_reg(CFG_ORIGIN_X, CFG_W'(ox));
        write_reg(CFG_ORIGIN_Z, CFG_W'(oz));
        write_reg(CFG_ORIGIN_Y, CFG_W'(oy));
    endtask

    function automatic map_op_t make_op(logic [1:0] mode, int row, int column, int sample,
                                        int wx, int wz);
        map_op_t op;
        op.mode    = mode;
        op.row     = 8'(row);
        op.column  = 8'(column);
        op.sample  = 8'(sample);
        op.world_x = 24'(wx);
        op.world_z = 24'(wz);
        return op;
    endfunction

    // World offset that lands within the first cells of the grid, at times anywhere on it, a little past either end
    function automatic int near_grid_offset(int org);
        int     span;
        longint reach;
        span = ($urandom_range(0, 9) == 0) ? grid_side() : ((grid_side() < 14) ? grid_side() : 14);
        if (cells_reg == 0)
            return org + int'($urandom_range(0, 2000)) - 1000;
        reach = (longint'(span - 1) << 24) / longint'(cells_reg);
        if (reach > 64'd8000000) reach = 8000000;
        return org + int'($urandom_range(0, int'(reach) + 20)) - 10;
    endfunction

    function automatic int small_index();
        return ($urandom_range(0, 9) < 7) ? $urandom_range(0, 15) : $urandom_range(0, 255);
    endfunction

    task automatic run_random(int count);
        map_op_t op;
        bit      unloaded;
        int      pick, tries;
        query_res_t res;
        repeat (count) begin
            tries = 0;
            do begin
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    op = make_op(MODE_WRITE, small_index(), small_index(),
                                 $urandom_range(0, 255), $urandom, $urandom);
                else if (pick < 55)
                    op = make_op(MODE_HEIGHT, $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 255), near_grid_offset(org_x_reg),
                                 near_grid_offset(org_z_reg));
                else if (pick < 88)
                    op = make_op(MODE_NORMAL, small_index(), small_index(),
                                 $urandom_range(0, 255), $urandom, $urandom);
                else if (pick < 94)
                    op = make_op(MODE_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    op = make_op(MODE_HEIGHT, $urandom, $urandom, $urandom, $urandom,
                                 $urandom);
                res = predict_query(op, unloaded);
                tries++;
            end while (unloaded && tries < 32);
            // Never read a map entry that was not loaded
            if (unloaded) op.mode = MODE_NONE;
            send_op(op);
        end
    endtask

    // Load the 12x12 corner so that queries have terrain to read
    task automatic test_fill_map();
        for (int r = 0; r < 12; r++)
            for (int c = 0; c < 12; c++)
                send_op(make_op(MODE_WRITE, r, c, (r == 0 && c == 0) ? 0 :
                                (r == 1 && c == 1) ? 255 : $urandom_range(0, 255), 0, 0));
    endtask

    // Field extremes, both triangles, the diagonal tie, the far cell and off-grid points
    task automatic test_directed();
        send_op(make_op(MODE_WRITE, 255, 255, 255, 24'h7FFFFF, 24'h800000));
        send_op(make_op(MODE_WRITE, 254, 255, 0, 0, 0));
        send_op(make_op(MODE_WRITE, 255, 254, 128, 0, 0));
        send_op(make_op(MODE_WRITE, 254, 254, 200, 0, 0));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 128, 64));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 200, 200));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 128, 128));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 0, 0));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 254 * 256 + 100, 254 * 256 + 250));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, -1, 0));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 0, -8388608));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 255 * 256, 0));
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 8388607, 8388607));
        send_op(make_op(MODE_NORMAL, 0, 0, 0, 0, 0));
        send_op(make_op(MODE_NORMAL, 5, 6, 0, 0, 0));
        send_op(make_op(MODE_NORMAL, 255, 255, 0, 0, 0));
        send_op(make_op(MODE_NONE, 255, 255, 255, -1, -1));
        send_op(make_op(MODE_WRITE, 11, 11, 128, 0, 0));
        // Upper triangle of cell (10, 10) reads the corner just rewritten
        send_op(make_op(MODE_HEIGHT, 0, 0, 0, 10 * 256 + 200, 10 * 256 + 200));
    endtask

    // Walk through register settings, the extremes among them
    task automatic test_terrain_sweep();
        int cfgs [7][6] = '{
            '{2, 65535, 16777215, -8388608, 8388607, 8388607},
            '{0, 0, 0, 0, 0, -8388608},
            '{5, 12345, 40000, -1000, 2000, 300},
            '{9, 300, 200000, 500, -500, -77},
            '{511, 1000, 196608, 0, 0, 0},
            '{256, 65535, 1, 8388607, -8388608, 5},
            '{12, 40000, 1000000, -3000, -3000, 123456}
        };
        for (int p = 0; p < 7; p++) begin
            set_terrain(cfgs[p][0], cfgs[p][1], cfgs[p][2], cfgs[p][3], cfgs[p][4],
                        cfgs[p][5]);
            send_gaps   = (p != 2);
            recv_stalls = (p != 2) && (p != 5);
            if (p == 2)
                send_op(make_op(MODE_NORMAL, 200, 3, 0, 0, 0));
            run_random(50);
        end
    endtask

    task automatic test_random_terrain();
        repeat (2) begin
            set_terrain($urandom_range(2, 16), $urandom_range(0, 65535),
                        $urandom_range(1000, 3000000), $urandom_range(0, 4000) - 2000,
                        $urandom_range(0, 4000) - 2000, $urandom);
            run_random(40);
        end
    endtask

    // Accept results, with random stalls while recv_stalls is set, and check each against the oldest expectation
    initial begin
        int         stall;
        query_res_t want;
        res_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = recv_stalls ? $urandom_range(0, 16) : 0;
            repeat (stall) begin
                @(negedge i_clk);
                res_if.ready = 1'b0;
            end
            @(negedge i_clk);
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            if (pending_q.size() == 0) begin
                $error("result with no transaction outstanding");
                fail_count++;
            end else begin
                want = pending_q.pop_front();
                if (res_if.height !== want.height) begin
                    $error("height expected %0h got %0h", want.height, res_if.height);
                    fail_count++;
                end
                if (res_if.outside !== want.outside) begin
                    $error("outside expected %0h got %0h", want.outside, res_if.outside);
                    fail_count++;
                end
                if (res_if.normal_x !== want.normal_x) begin
                    $error("normal_x expected %0h got %0h", want.normal_x, res_if.normal_x);
                    fail_count++;
                end
                if (res_if.normal_y !== want.normal_y) begin
                    $error("normal_y expected %0h got %0h", want.normal_y, res_if.normal_y);
                    fail_count++;
                end
                if (res_if.normal_z !== want.normal_z) begin
                    $error("normal_z expected %0h got %0h", want.normal_z, res_if.normal_z);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count    = 0;
        send_gaps     = 1'b1;
        recv_stalls   = 1'b1;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        item_if.valid = 1'b0;
        item_if.mode  = MODE_WRITE;
        item_if.row   = '0;
        item_if.column = '0;
        item_if.sample = '0;
        item_if.world_x = '0;
        item_if.world_z = '0;
        side_reg  = 9'd256;
        max_h_reg = 16'd256;
        cells_reg = 24'd65536;
        org_x_reg = '0;
        org_z_reg = '0;
        org_y_reg = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_fill_map();
        test_directed();
        run_random(40);
        test_terrain_sweep();
        test_random_terrain();

        // Drain, then give the block time to show any stray result
        @(negedge i_clk);
        item_if.valid = 1'b0;
        wait (pending_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
